// File: rtl/iclp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the init command list interpreter.
// No dependencies; imported by every module of the block.
package iclp_pkg;

	localparam logic [7:0]  LONG_CODE        = 8'd255;
	localparam logic [15:0] LONG_DELAY_RESET = 16'd500;

	// result kinds as seen on the output port
	typedef enum logic [1:0] {
		KIND_CMD   = 2'd0,
		KIND_DATA  = 2'd1,
		KIND_DELAY = 2'd2,
		KIND_END   = 2'd3
	} kind_t;

	// parser phases, one-hot
	typedef enum logic [4:0] {
		PH_COUNT = 5'b00001,
		PH_CMD   = 5'b00010,
		PH_ARGC  = 5'b00100,
		PH_ARG   = 5'b01000,
		PH_DELAY = 5'b10000
	} phase_t;

	// classified item passed from the parser to the output side
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       long_dly;
		logic       list_end;
	} entry_t;

endpackage

// File: rtl/iclp_front.sv
`timescale 1ns / 1ps
// Parser: accepts list bytes, tracks command/argument phase, classifies each item.
// Depends on iclp_pkg; pushes classified entries into iclp_fifo.
module iclp_front
	import iclp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  logic [7:0] list_byte,
	input  logic   q_full,
	output logic   push,
	output entry_t push_entry
);

	phase_t     phase_q, phase_d;
	logic [7:0] cmds_left_q, cmds_left_d;
	logic [6:0] args_left_q, args_left_d;
	logic       dly_wanted_q, dly_wanted_d;
	logic [6:0] args_dec;
	logic       gen;
	logic       accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && gen;
	assign args_dec = args_left_q - 7'd1;

	always_comb begin
		phase_d      = phase_q;
		cmds_left_d  = cmds_left_q;
		args_left_d  = args_left_q;
		dly_wanted_d = dly_wanted_q;
		gen          = 1'b0;
		push_entry   = '{kind: KIND_END, data: list_byte, long_dly: 1'b0, list_end: 1'b0};
		case (phase_q)
			PH_CMD: begin
				cmds_left_d     = cmds_left_q - 8'd1;
				phase_d         = PH_ARGC;
				gen             = 1'b1;
				push_entry.kind = KIND_CMD;
			end
			PH_ARGC: begin
				dly_wanted_d = list_byte[7];
				args_left_d  = list_byte[6:0];
				if (list_byte[6:0] != 7'd0) begin
					phase_d = PH_ARG;
				end else if (list_byte[7]) begin
					phase_d = PH_DELAY;
				end else if (cmds_left_q == 8'd0) begin
					// last command had nothing after it: mark the end here
					phase_d             = PH_COUNT;
					gen                 = 1'b1;
					push_entry.kind     = KIND_END;
					push_entry.list_end = 1'b1;
				end else begin
					phase_d = PH_CMD;
				end
			end
			PH_ARG: begin
				args_left_d     = args_dec;
				gen             = 1'b1;
				push_entry.kind = KIND_DATA;
				if (args_dec == 7'd0) begin
					if (dly_wanted_q) begin
						phase_d = PH_DELAY;
					end else if (cmds_left_q == 8'd0) begin
						phase_d             = PH_COUNT;
						push_entry.list_end = 1'b1;
					end else begin
						phase_d = PH_CMD;
					end
				end
			end
			PH_DELAY: begin
				dly_wanted_d        = 1'b0;
				gen                 = 1'b1;
				push_entry.kind     = KIND_DELAY;
				push_entry.long_dly = (list_byte == LONG_CODE);
				if (cmds_left_q == 8'd0) begin
					phase_d             = PH_COUNT;
					push_entry.list_end = 1'b1;
				end else begin
					phase_d = PH_CMD;
				end
			end
			default: begin
				// count byte (also recovers from any stray code)
				cmds_left_d  = list_byte;
				args_left_d  = 7'd0;
				dly_wanted_d = 1'b0;
				if (list_byte == 8'd0) begin
					phase_d             = PH_COUNT;
					gen                 = 1'b1;
					push_entry.kind     = KIND_END;
					push_entry.list_end = 1'b1;
				end else begin
					phase_d = PH_CMD;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_COUNT;
			cmds_left_q  <= 8'd0;
			args_left_q  <= 7'd0;
			dly_wanted_q <= 1'b0;
		end else if (accept) begin
			phase_q      <= phase_d;
			cmds_left_q  <= cmds_left_d;
			args_left_q  <= args_left_d;
			dly_wanted_q <= dly_wanted_d;
		end
	end

endmodule

// File: rtl/iclp_fifo.sv
`timescale 1ns / 1ps
// Small register queue between parser and output stage.
// Depends on iclp_pkg for the entry type.
module iclp_fifo
	import iclp_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   not_empty,
	output entry_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	entry_t          slots_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign head      = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: rtl/iclp_back.sv
`timescale 1ns / 1ps
// Output stage: holds the long-delay register, expands queued entries into results.
// Depends on iclp_pkg; reads entries from iclp_fifo.
module iclp_back
	import iclp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        q_not_empty,
	input  entry_t      q_head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  value,
	output logic [15:0] wait_ms,
	output logic        list_end
);

	logic [15:0] long_delay_q;
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  value_q;
	logic [15:0] wait_ms_q;
	logic        list_end_q;

	// output register refills whenever it is empty or being taken and the queue is not empty
	assign pop = q_not_empty && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_delay_q <= LONG_DELAY_RESET;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				long_delay_q <= cfg_wr_data;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q     <= q_head.kind;
			list_end_q <= q_head.list_end;
			value_q    <= (q_head.kind == KIND_CMD || q_head.kind == KIND_DATA) ?
			              q_head.data : 8'd0;
			if (q_head.kind == KIND_DELAY) begin
				wait_ms_q <= q_head.long_dly ? long_delay_q : {8'd0, q_head.data};
			end else begin
				wait_ms_q <= 16'd0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign value     = value_q;
	assign wait_ms   = wait_ms_q;
	assign list_end  = list_end_q;

endmodule

// File: rtl/init_command_list_interpreter.sv
`timescale 1ns / 1ps
// Init command list interpreter: one list byte accepted per cycle when the queue has room.
// Each result is registered in the queue, then in the output register, before it is offered.
// Throughput: one byte per cycle sustained; a stalled output backs up through the queue.
// Reset (arst_n low): parser expects a count byte, queue and output empty, long delay 500 ms.
// Depends on iclp_pkg, iclp_front, iclp_fifo, iclp_back.
module init_command_list_interpreter
	import iclp_pkg::*;
#(
	parameter int FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  list_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  value,
	output logic [15:0] wait_ms,
	output logic        list_end
);

	logic   push, q_full, pop, q_not_empty;
	entry_t push_entry, q_head;

	iclp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.list_byte  (list_byte),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	iclp_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.not_empty  (q_not_empty),
		.head       (q_head)
	);

	iclp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.value       (value),
		.wait_ms     (wait_ms),
		.list_end    (list_end)
	);

endmodule
